>>> hdl/spq_pkg.sv
// Shared types and constants for the stable priority queue.
package spq_pkg;

  // Number of entry cells in the chain.
  localparam int CAPACITY = 16;
  // Bits to hold a count from zero up to CAPACITY.
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Result status codes.
  localparam logic [1:0] ST_INSERTED  = 2'd0;
  localparam logic [1:0] ST_REMOVED   = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [1:0] ST_OVERFLOW  = 2'd3;

  // Command codes.
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // One held entry as it moves along the chain.
  typedef struct packed {
    logic               occ;
    logic signed [31:0] data;
    logic signed [31:0] prio;
  } entry_t;

  // Per-cycle shift control broadcast to every cell.
  typedef struct packed {
    logic shift_in;   // insert: open a gap and place the new entry
    logic shift_out;  // remove: every entry moves one place to the front
  } ctrl_t;

endpackage

>>> hdl/spq_cell.sv
// One slot of the sorted chain: holds an entry, compares and shifts.
module spq_cell import spq_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  ctrl_t              ctrl,
  input  logic signed [31:0] data_in,
  input  logic signed [31:0] priority_in,
  input  entry_t             left,
  input  logic               left_open,
  input  entry_t             right,
  output entry_t             cur,
  output logic               open
);

  entry_t cur_next;

  // Open means the new word belongs at or in front of this slot.
  assign open = !cur.occ || (cur.prio > priority_in);

  // Pick the next content from hold, left neighbor, new word or right neighbor.
  always_comb begin
    cur_next = cur;
    if (ctrl.shift_in) begin
      if (left_open) begin
        cur_next = left;
      end else if (open) begin
        cur_next.occ  = 1'b1;
        cur_next.data = data_in;
        cur_next.prio = priority_in;
      end
    end else if (ctrl.shift_out) begin
      cur_next = right;
    end
  end

  // Occupied flag is control state and is cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur.occ <= 1'b0;
    end else begin
      cur.occ <= cur_next.occ;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    cur.data <= cur_next.data;
    cur.prio <= cur_next.prio;
  end

endmodule

>>> hdl/stable_priority_queue_core.sv
// Top level of the stable priority queue: chain of cells plus result register.
//
// A bounded priority queue built as a row of CAPACITY cells kept in ascending
// priority order, the front entry in cell 0. Every cell compares the incoming
// priority against its own in parallel and the whole row shifts together, so
// one word is accepted every cycle while the result register can be emptied;
// the result of a word is registered and appears in the cycle after it is
// accepted. Equal priorities keep arrival order. A remove on an empty queue
// reports underflow, an insert on a full queue is refused and reports
// overflow; in both cases data_out and priority_out are zero.
// count_out gives the number of entries held after the step, low 5 bits.
module stable_priority_queue_core import spq_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               command,
  input  logic signed [31:0] data_in,
  input  logic signed [31:0] priority_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic signed [31:0] data_out,
  output logic signed [31:0] priority_out,
  output logic [4:0]         count_out
);

  entry_t             cells  [CAPACITY];
  logic               opens  [CAPACITY];
  ctrl_t              ctrl;
  logic               accept;
  logic               full;
  logic               empty;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic [CNT_W+4:0]   count_ext;
  logic [1:0]         status_next;

  // Take a new word whenever the result register is free or being drained.
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign full  = cells[CAPACITY-1].occ;
  assign empty = !cells[0].occ;

  assign ctrl.shift_in  = accept && (command == CMD_INSERT) && !full;
  assign ctrl.shift_out = accept && (command == CMD_REMOVE) && !empty;

  // Build the chain; the ends see an empty neighbor.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_e;
    entry_t right_e;
    logic   left_o;

    if (i == 0) begin : g_first
      assign left_e = '0;
      assign left_o = 1'b0;
    end else begin : g_mid
      assign left_e = cells[i-1];
      assign left_o = opens[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_inner
      assign right_e = cells[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .data_in     (data_in),
      .priority_in (priority_in),
      .left        (left_e),
      .left_open   (left_o),
      .right       (right_e),
      .cur         (cells[i]),
      .open        (opens[i])
    );
  end

  // Track the number of held entries.
  always_comb begin
    count_next = count;
    if (ctrl.shift_in) begin
      count_next = count + CNT_W'(1);
    end else if (ctrl.shift_out) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Decide the status of the accepted word.
  always_comb begin
    if (command == CMD_INSERT) begin
      status_next = full ? ST_OVERFLOW : ST_INSERTED;
    end else begin
      status_next = empty ? ST_UNDERFLOW : ST_REMOVED;
    end
  end

  // Hold the result until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign count_ext = {5'b0, count_next};

  always_ff @(posedge clk) begin
    if (accept) begin
      status    <= status_next;
      count_out <= count_ext[4:0];
      if (ctrl.shift_out) begin
        data_out     <= cells[0].data;
        priority_out <= cells[0].prio;
      end else begin
        data_out     <= '0;
        priority_out <= '0;
      end
    end
  end

endmodule

>>> bench/stable_priority_queue_core_tb.sv
// Self-checking testbench for the stable priority queue core.
module stable_priority_queue_core_tb import spq_pkg::*;;

  localparam int RANDOM_ITEMS = 1750;
  // Run without idling once the backlog gets this short.
  localparam int TAIL_ITEMS = 150;
  localparam int RETUNE_EVERY = 64;
  localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] WORD_MAX = 32'sh7FFF_FFFF;

  typedef struct {
    logic               cmd;
    logic signed [31:0] data;
    logic signed [31:0] prio;
  } queue_cmd_t;

  typedef struct {
    logic [1:0]         status;
    logic signed [31:0] data;
    logic signed [31:0] prio;
    logic [4:0]         count;
  } queue_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               command = CMD_INSERT;
  logic signed [31:0] data_in = '0;
  logic signed [31:0] priority_in = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         status;
  logic signed [31:0] data_out;
  logic signed [31:0] priority_out;
  logic [4:0]         count_out;

  // Shadow copy of the held entries, front at slot 0.
  logic signed [31:0] held_data [CAPACITY];
  logic signed [31:0] held_prio [CAPACITY];
  int                 held_count = 0;

  queue_cmd_t    cmd_backlog[$];
  queue_result_t pending_results[$];
  queue_cmd_t    next_cmd;
  queue_result_t expected_word;

  int mismatch_count = 0;
  int sent_count = 0;
  int recv_count = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int send_idle_pct = 20;
  int recv_stall_pct = 20;

  stable_priority_queue_core dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .data_in      (data_in),
    .priority_in  (priority_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .data_out     (data_out),
    .priority_out (priority_out),
    .count_out    (count_out)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Apply one command to the shadow queue and record the result it must give.
  task automatic apply_queue_op(input logic cmd, input logic signed [31:0] d,
                                input logic signed [31:0] p);
    queue_result_t r;
    int slot;
    r.data = '0;
    r.prio = '0;
    if (cmd == CMD_INSERT) begin
      if (held_count >= CAPACITY) begin
        r.status = ST_OVERFLOW;
      end else begin
        // Place behind every entry whose priority is not greater.
        slot = held_count;
        for (int i = held_count - 1; i >= 0; i--) begin
          if (held_prio[i] > p) slot = i;
        end
        for (int i = held_count; i > slot; i--) begin
          held_data[i] = held_data[i - 1];
          held_prio[i] = held_prio[i - 1];
        end
        held_data[slot] = d;
        held_prio[slot] = p;
        held_count++;
        r.status = ST_INSERTED;
      end
    end else begin
      if (held_count == 0) begin
        r.status = ST_UNDERFLOW;
      end else begin
        r.data = held_data[0];
        r.prio = held_prio[0];
        for (int i = 1; i < held_count; i++) begin
          held_data[i - 1] = held_data[i];
          held_prio[i - 1] = held_prio[i];
        end
        held_count--;
        r.status = ST_REMOVED;
      end
    end
    r.count = 5'(held_count);
    pending_results.push_back(r);
  endtask

  task automatic push_cmd(input logic cmd, input logic signed [31:0] d,
                          input logic signed [31:0] p);
    queue_cmd_t c;
    c.cmd = cmd;
    c.data = d;
    c.prio = p;
    cmd_backlog.push_back(c);
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%08h, got 0x%08h", field, want, got);
      mismatch_count++;
    end
  endtask

  // Favor narrow priority ranges so ties are common.
  function automatic logic signed [31:0] draw_priority();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return $urandom_range(0, 7) - 3;
    if (pick < 8) return $urandom;
    case ($urandom_range(0, 3))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return 32'sd0;
      default: return -32'sd1;
    endcase
  endfunction

  // Zero gives a stretch with no idling at all.
  function automatic int draw_stall_pct();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 5;
      2: return 20;
      default: return 50;
    endcase
  endfunction

  // Drive command words; hold each until accepted, then predict its result.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        apply_queue_op(command, data_in, priority_in);
        sent_count++;
        if (sent_count % RETUNE_EVERY == 0) send_idle_pct = draw_stall_pct();
      end
      if (!in_valid || in_ready) begin
        if (send_gap == 0 && cmd_backlog.size() > TAIL_ITEMS &&
            $urandom_range(0, 99) < send_idle_pct)
          send_gap = $urandom_range(1, 12);
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (cmd_backlog.size() > 0) begin
          next_cmd = cmd_backlog.pop_front();
          in_valid <= 1'b1;
          command <= next_cmd.cmd;
          data_in <= next_cmd.data;
          priority_in <= next_cmd.prio;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Take result words, compare against the oldest prediction, stall at random.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result word: status %0d, count %0d", status, count_out);
          mismatch_count++;
        end else begin
          expected_word = pending_results.pop_front();
          check_field("status", 32'(expected_word.status), 32'(status));
          check_field("data_out", expected_word.data, data_out);
          check_field("priority_out", expected_word.prio, priority_out);
          check_field("count_out", 32'(expected_word.count), 32'(count_out));
        end
        recv_count++;
        if (recv_count % RETUNE_EVERY == 0) recv_stall_pct = draw_stall_pct();
      end
      if (recv_gap == 0 && cmd_backlog.size() > TAIL_ITEMS &&
          $urandom_range(0, 99) < recv_stall_pct)
        recv_gap = $urandom_range(1, 12);
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int seg_len;
    int insert_pct;
    int total;
    logic cmd;

    // Underflow on an empty queue.
    push_cmd(CMD_REMOVE, 32'sd0, 32'sd0);
    // Extreme data and priorities, then ties at zero and at both ends.
    push_cmd(CMD_INSERT, WORD_MIN, WORD_MAX);
    push_cmd(CMD_INSERT, WORD_MAX, WORD_MIN);
    push_cmd(CMD_INSERT, -32'sd1, 32'sd0);
    push_cmd(CMD_INSERT, 32'sd0, -32'sd1);
    push_cmd(CMD_INSERT, 32'sd1, 32'sd0);
    push_cmd(CMD_INSERT, 32'sd2, 32'sd0);
    push_cmd(CMD_INSERT, 32'sd3, WORD_MAX);
    push_cmd(CMD_INSERT, 32'sd4, WORD_MIN);
    // Fill to capacity with equal priorities, then overflow.
    for (int i = 0; i < 8; i++) push_cmd(CMD_INSERT, 32'sd16 + i, 32'sd5);
    push_cmd(CMD_INSERT, 32'sh5A5A_5A5A, WORD_MIN);
    // Remove from a full queue, refill behind existing ties, overflow again.
    repeat (3) push_cmd(CMD_REMOVE, $urandom, $urandom);
    for (int i = 0; i < 3; i++) push_cmd(CMD_INSERT, 32'sd32 + i, 32'sd0);
    push_cmd(CMD_INSERT, 32'shA5A5_A5A5, WORD_MAX);

    // Random segments that lean toward filling, draining or staying level.
    total = 0;
    while (total < RANDOM_ITEMS) begin
      seg_len = $urandom_range(8, 48);
      case ($urandom_range(0, 2))
        0: insert_pct = 85;
        1: insert_pct = 15;
        default: insert_pct = 50;
      endcase
      repeat (seg_len) begin
        cmd = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
        push_cmd(cmd, $urandom, draw_priority());
        total++;
      end
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (cmd_backlog.size() != 0 || in_valid || pending_results.size() != 0)
      @(negedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
